### rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define CHK_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication.
`define CHK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### rtl/isots_pkg.sv
// ----------------------------------------------------------------------------
// isots_pkg: CD-ROM timestamp conversion package
// Payload types, calendar constants and digit helpers.
// ----------------------------------------------------------------------------
package isots_pkg;

	localparam int unsigned YEAR_W = 20;   // signed decoded year offset
	localparam int unsigned FLD_W  = 13;   // signed decoded two-digit field
	localparam int unsigned ZADJ_W = 17;   // signed zone correction, seconds

	localparam logic [7:0]         ASCII_ZERO       = 8'd48;
	localparam logic signed [19:0] EPOCH_YEAR       = 20'sd1970;
	localparam logic signed [19:0] EPOCH_YEAR_SHORT = 20'sd70;
	localparam logic signed [7:0]  ZONE_MIN         = -8'sd48;
	localparam logic signed [7:0]  ZONE_MAX         = 8'sd52;
	localparam logic [31:0]        DAYS_PER_YEAR    = 32'd365;
	localparam logic [31:0]        HOURS_PER_DAY    = 32'd24;
	localparam logic [31:0]        SECS_PER_MIN     = 32'd60;
	localparam logic [31:0]        MINS_PER_HOUR    = 32'd60;
	localparam logic signed [16:0] SECS_PER_QUARTER = 17'sd900; // 15 * 60

	typedef struct packed {
		logic              is_long_form;
		logic [31:0]       year_raw;
		logic [15:0]       month_raw;
		logic [15:0]       day_raw;
		logic [15:0]       hour_raw;
		logic [15:0]       minute_raw;
		logic [15:0]       second_raw;
		logic signed [7:0] zone_quarters;
	} ts_in_t;

	typedef struct packed {
		logic signed [31:0] epoch_seconds;
		logic               date_valid;
	} epoch_out_t;

	// One ASCII byte minus '0', no digit check: -48..207.
	function automatic logic signed [8:0] ascii_digit(input logic [7:0] b);
		return $signed({1'b0, b}) - $signed({1'b0, ASCII_ZERO});
	endfunction

	// Two ASCII digits, tens in the upper byte.
	function automatic logic signed [FLD_W-1:0] ascii_pair(input logic [15:0] w);
		logic signed [FLD_W-1:0] hi;
		logic signed [FLD_W-1:0] lo;
		hi = FLD_W'(ascii_digit(w[15:8]));
		lo = FLD_W'(ascii_digit(w[7:0]));
		return hi * 13'sd10 + lo;
	endfunction

	// Four ASCII year digits, minus 1970.
	function automatic logic signed [YEAR_W-1:0] ascii_year(input logic [31:0] w);
		logic signed [YEAR_W-1:0] d3;
		logic signed [YEAR_W-1:0] d2;
		logic signed [YEAR_W-1:0] d1;
		logic signed [YEAR_W-1:0] d0;
		d3 = YEAR_W'(ascii_digit(w[31:24]));
		d2 = YEAR_W'(ascii_digit(w[23:16]));
		d1 = YEAR_W'(ascii_digit(w[15:8]));
		d0 = YEAR_W'(ascii_digit(w[7:0]));
		return d3 * 20'sd1000 + d2 * 20'sd100 + d1 * 20'sd10 + d0 - EPOCH_YEAR;
	endfunction

	// Days before the first of a month; codes outside 1..12 never reach output.
	function automatic logic [8:0] days_before(input logic [3:0] m);
		logic [8:0] d;
		case (m)
			4'd1:    d = 9'd0;
			4'd2:    d = 9'd31;
			4'd3:    d = 9'd59;
			4'd4:    d = 9'd90;
			4'd5:    d = 9'd120;
			4'd6:    d = 9'd151;
			4'd7:    d = 9'd181;
			4'd8:    d = 9'd212;
			4'd9:    d = 9'd243;
			4'd10:   d = 9'd273;
			4'd11:   d = 9'd304;
			4'd12:   d = 9'd334;
			default: d = 9'd0;
		endcase
		return d;
	endfunction

endpackage

### rtl/iso_timestamp_to_epoch.sv
// ----------------------------------------------------------------------------
// iso_timestamp_to_epoch: CD-ROM timestamp to seconds since 1970
// Five-stage pipeline converting short or long form timestamps to Unix time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel ts/ts_valid/ts_stall carries one timestamp per transaction,
//   either the 7-byte binary form or the 17-byte ASCII digit form (raw digit
//   bytes), plus a signed quarter-hour zone offset.
//   Output channel epoch/epoch_valid/epoch_stall returns one transaction per
//   input: seconds since 1970-01-01 UTC, mod 2^32, and a date_valid flag.
//   Year before 1970 or month outside 1..12 gives zero seconds, flag low.
//   Zone offsets outside -48..52 quarters are ignored.
// Timing:
//   epoch_valid is the stage 5 valid bit. Throughput is one transaction per
//   cycle while not stalled; the stage depth is set by one constant multiply
//   plus add per stage (x365 day count, then x24, x60, x60).
// Reset:
//   arst_n clears every stage valid bit; no result is pending afterwards.
// Stall:
//   Each stage holds while it is full and the stage after it holds, so
//   bubbles close up under a stalled output. ts_stall rises only when all
//   five stages are full and epoch_stall is high.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module iso_timestamp_to_epoch
	import isots_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       ts_valid,
	output logic       ts_stall,
	input  ts_in_t     ts,
	output logic       epoch_valid,
	input  logic       epoch_stall,
	output epoch_out_t epoch
);

	// ------------------------------------------------------------------
	// Stage enables: a stage loads when empty or when its successor moves
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic en_s1, en_s2, en_s3, en_s4, en_s5;

	assign en_s5    = !v_s5 || !epoch_stall;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign ts_stall = !en_s1;

	// ------------------------------------------------------------------
	// Stage 1: field decode, range check, zone correction
	// ------------------------------------------------------------------
	logic signed [YEAR_W-1:0] year_c;
	logic signed [FLD_W-1:0]  month_c, day_c, hour_c, minute_c, second_c;
	logic                     ok_c;
	logic                     zone_in_range;
	logic signed [ZADJ_W-1:0] zadj_c;

	always_comb begin
		if (ts.is_long_form) begin
			year_c   = ascii_year(ts.year_raw);
			month_c  = ascii_pair(ts.month_raw);
			day_c    = ascii_pair(ts.day_raw);
			hour_c   = ascii_pair(ts.hour_raw);
			minute_c = ascii_pair(ts.minute_raw);
			second_c = ascii_pair(ts.second_raw);
		end else begin
			year_c   = $signed({12'd0, ts.year_raw[7:0]}) - EPOCH_YEAR_SHORT;
			month_c  = $signed({5'd0, ts.month_raw[7:0]});
			day_c    = $signed({5'd0, ts.day_raw[7:0]});
			hour_c   = $signed({5'd0, ts.hour_raw[7:0]});
			minute_c = $signed({5'd0, ts.minute_raw[7:0]});
			second_c = $signed({5'd0, ts.second_raw[7:0]});
		end
		ok_c = (year_c >= 20'sd0) && (month_c >= 13'sd1) && (month_c <= 13'sd12);
		zone_in_range = (ts.zone_quarters >= ZONE_MIN) && (ts.zone_quarters <= ZONE_MAX);
		zadj_c = zone_in_range ? ZADJ_W'(ts.zone_quarters) * SECS_PER_QUARTER
		                       : '0;
	end

	logic [17:0]              year_s1;   // non-negative when ok
	logic [3:0]               month_s1;
	logic signed [FLD_W-1:0]  day_s1, hour_s1, minute_s1, second_s1;
	logic signed [ZADJ_W-1:0] zadj_s1;
	logic                     ok_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= ts_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && ts_valid) begin
			year_s1   <= year_c[17:0];
			month_s1  <= month_c[3:0];
			day_s1    <= day_c;
			hour_s1   <= hour_c;
			minute_s1 <= minute_c;
			second_s1 <= second_c;
			zadj_s1   <= zadj_c;
			ok_s1     <= ok_c;
		end
	end

	// ------------------------------------------------------------------
	// Stage 2: day count (years, leap days, month table, day of month)
	// ------------------------------------------------------------------
	logic [18:0] year_p2;
	logic        leap_adj;
	logic [31:0] days_c;

	always_comb begin
		year_p2  = {1'b0, year_s1} + 19'd2;
		leap_adj = (year_p2[1:0] == 2'd0) && (month_s1 <= 4'd2);
		days_c   = 32'(year_s1) * DAYS_PER_YEAR + 32'(year_p2[18:2])
		         + 32'(days_before(month_s1)) - 32'(leap_adj)
		         + 32'(day_s1) - 32'd1;
	end

	logic [31:0]              days_s2;
	logic signed [FLD_W-1:0]  hour_s2, minute_s2, second_s2;
	logic signed [ZADJ_W-1:0] zadj_s2;
	logic                     ok_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			days_s2   <= days_c;
			hour_s2   <= hour_s1;
			minute_s2 <= minute_s1;
			second_s2 <= second_s1;
			zadj_s2   <= zadj_s1;
			ok_s2     <= ok_s1;
		end
	end

	// ------------------------------------------------------------------
	// Stage 3: hours
	// ------------------------------------------------------------------
	logic [31:0]              hours_s3;
	logic signed [FLD_W-1:0]  minute_s3, second_s3;
	logic signed [ZADJ_W-1:0] zadj_s3;
	logic                     ok_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			hours_s3  <= days_s2 * HOURS_PER_DAY + 32'(hour_s2);
			minute_s3 <= minute_s2;
			second_s3 <= second_s2;
			zadj_s3   <= zadj_s2;
			ok_s3     <= ok_s2;
		end
	end

	// ------------------------------------------------------------------
	// Stage 4: minutes
	// ------------------------------------------------------------------
	logic [31:0]              mins_s4;
	logic signed [FLD_W-1:0]  second_s4;
	logic signed [ZADJ_W-1:0] zadj_s4;
	logic                     ok_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			mins_s4   <= hours_s3 * MINS_PER_HOUR + 32'(minute_s3);
			second_s4 <= second_s3;
			zadj_s4   <= zadj_s3;
			ok_s4     <= ok_s3;
		end
	end

	// ------------------------------------------------------------------
	// Stage 5: seconds, zone correction, output register
	// ------------------------------------------------------------------
	logic [31:0] secs_c;
	epoch_out_t  epoch_s5;

	assign secs_c = mins_s4 * SECS_PER_MIN + 32'(second_s4) - 32'(zadj_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en_s5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && v_s4) begin
			epoch_s5.epoch_seconds <= ok_s4 ? $signed(secs_c) : 32'sd0;
			epoch_s5.date_valid    <= ok_s4;
		end
	end

	assign epoch_valid = v_s5;
	assign epoch       = epoch_s5;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`CHK_IMPLY(a_invalid_is_zero, epoch_valid && !epoch.date_valid, epoch.epoch_seconds == 32'sd0)
	`CHK_IMPLY(a_stall_only_when_full, ts_stall, v_s1 && v_s2 && v_s3 && v_s4 && v_s5 && epoch_stall)
	`CHK_NEXT(a_s1_moves_on, v_s1 && en_s2, v_s2)
	`CHK_NEXT(a_accept_fills_s1, ts_valid && !ts_stall, v_s1)

endmodule
